/* rtl/core/srde_pkg.sv */
// ----------------------------------------------------------------------------
// srde_pkg - shared types, constants and helpers for the radix digit emitter
// Holds the register map, symbol codes, divider handshake structs and the
// alphabet lookup and validity check.
// ----------------------------------------------------------------------------
package srde_pkg;

    localparam int unsigned MAX_RADIX   = 16;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned DIGIT_DEPTH = 32;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned ALPHA_W     = 2 * CFG_W;
    localparam int unsigned COUNT_W     = $clog2(DIGIT_DEPTH + 1);

    // Quotient bits resolved per divider cycle, and the cycles per division
    localparam int unsigned DIV_BITS_PER_CYC = 8;
    localparam int unsigned DIV_CYCLES       = VALUE_W / DIV_BITS_PER_CYC;
    localparam int unsigned DIV_STEP_W       = $clog2(DIV_CYCLES);

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } t_div_rsp;

    // Symbol for one digit; alpha holds digit 0 in its low byte
    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [DIGIT_W-1:0] d,
        input logic [ALPHA_W-1:0] alpha
    );
        return alpha[{d, 3'b000} +: SYM_W];
    endfunction

    // Radix in range, no sign symbol and no repeated symbol among those in use
    function automatic logic alphabet_ok(
        input logic [RADIX_W-1:0] radix,
        input logic [ALPHA_W-1:0] alpha
    );
        logic ok;
        ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            if (RADIX_W'(i) < radix) begin
                if (symbol_of(DIGIT_W'(i), alpha) == SYM_PLUS ||
                    symbol_of(DIGIT_W'(i), alpha) == SYM_MINUS) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (RADIX_W'(j) < radix &&
                        symbol_of(DIGIT_W'(j), alpha) == symbol_of(DIGIT_W'(i), alpha)) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

/* rtl/core/srde_div.sv */
// ----------------------------------------------------------------------------
// srde_div - iterative divider of a 32-bit magnitude by the radix
// Restoring division, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module srde_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srde_pkg::t_div_req i_req,
    output srde_pkg::t_div_rsp o_rsp
);
    import srde_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [VALUE_W-1:0]    r_dvd;
    logic [DIGIT_W-1:0]    r_rem;
    logic [VALUE_W-1:0]    n_dvd;
    logic [DIGIT_W-1:0]    n_rem;

    // Eight shift/compare/subtract steps on the narrow partial remainder
    always_comb begin
        logic [RADIX_W-1:0] t;
        logic               ge;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
            t     = {n_rem, n_dvd[VALUE_W-1]};
            ge    = (t >= i_req.divisor);
            n_rem = ge ? DIGIT_W'(t - i_req.divisor) : DIGIT_W'(t);
            n_dvd = {n_dvd[VALUE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
            r_dvd  <= i_req.dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
            r_step <= r_step + 1'b1;
            if (r_step == DIV_STEP_W'(DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_dvd;
    assign o_rsp.remainder = r_rem;

endmodule

/* rtl/core/signed_radix_digit_emitter_top.sv */
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_top - signed integer to radix symbol string
// Converts a signed 32-bit value to alphabet symbols, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis) carries one signed 32-bit value per transfer.
//   Master stream (m_axis) carries one 8-bit symbol per transfer; tlast
//   marks the final symbol of a value. Negative values start with '-'.
//   The config port sets radix (index 0) and the 16-symbol alphabet
//   (indexes 1 and 2); write it only while the block is idle.
//   If the radix is outside 2..16 or the symbols in use contain '+', '-'
//   or a repeat, an accepted value produces no symbols at all.
// Operation:
//   Each digit takes one division in the shared divider, which restarts
//   on the quotient. Digits are pushed on a 32-deep stack, then popped
//   one symbol per cycle while the output register is free. The most
//   negative value in binary needs a sign and 32 digits.
//   tready is high only between items; the final symbol may still sit in
//   the output register while the next value is taken.
// Reset: clears config, state machine, stack count and output valid.
// Stall: a held output register simply pauses popping; nothing is lost.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave stream: tdata = value[31:0] (signed)
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic signed [srde_pkg::VALUE_W-1:0]   i_s_axis_tdata,
    // Master stream: tdata = symbol[7:0]; tlast = last
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [srde_pkg::SYM_W-1:0]            o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [srde_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [srde_pkg::CFG_W-1:0]            i_cfg_wdata
);
    import srde_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                           r_state;
    logic [RADIX_W-1:0]               r_radix;
    logic [ALPHA_W-1:0]               r_alpha;
    logic [DIGIT_DEPTH*DIGIT_W-1:0]   r_stack;
    logic [COUNT_W-1:0]               r_count;
    logic                             r_neg;
    logic                             r_ovalid;
    logic [SYM_W-1:0]                 r_osym;
    logic                             r_olast;

    t_div_req                         div_req;
    t_div_rsp                         div_rsp;

    logic                             s_accept;
    logic                             cfg_ok;
    logic [VALUE_W-1:0]               in_mag;
    logic                             more_digits;
    logic                             out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_ok          = alphabet_ok(r_radix, r_alpha);

    // Magnitude in unsigned arithmetic: the most negative value maps to 2^31
    assign in_mag = i_s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_s_axis_tdata))
                                               : VALUE_W'(i_s_axis_tdata);

    // Keep dividing while the quotient is nonzero and the stack has room
    assign more_digits = (div_rsp.quotient != '0) &&
                         (r_count != COUNT_W'(DIGIT_DEPTH - 1));

    assign out_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        div_req.divisor = r_radix;
        if (r_state == S_IDLE) begin
            div_req.start    = s_accept && cfg_ok;
            div_req.dividend = in_mag;
        end else begin
            div_req.start    = (r_state == S_DIV) && div_rsp.done && more_digits;
            div_req.dividend = div_rsp.quotient;
        end
    end

    srde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radix  <= '0;
            r_alpha  <= '0;
            r_count  <= '0;
            r_neg    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // Config writes; unknown indexes drop
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RADIX:      r_radix <= RADIX_W'(i_cfg_wdata);
                    CFG_ALPHA_LOW:  r_alpha[CFG_W-1:0] <= i_cfg_wdata;
                    CFG_ALPHA_HIGH: r_alpha[ALPHA_W-1:CFG_W] <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // Drain the output register outside emission; while emitting,
            // a taken symbol is replaced by the next one below
            if (r_ovalid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    // A bad alphabet swallows the value with no symbols
                    if (s_accept && cfg_ok) begin
                        r_neg   <= i_s_axis_tdata[VALUE_W-1];
                        r_count <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Push the new least significant digit
                    if (div_rsp.done) begin
                        r_stack <= {r_stack[(DIGIT_DEPTH-1)*DIGIT_W-1:0], div_rsp.remainder};
                        r_count <= r_count + 1'b1;
                        if (!more_digits) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_neg) begin
                            r_osym  <= SYM_MINUS;
                            r_olast <= 1'b0;
                            r_neg   <= 1'b0;
                        end else begin
                            // Pop the most significant remaining digit
                            r_osym  <= symbol_of(r_stack[DIGIT_W-1:0], r_alpha);
                            r_olast <= (r_count == COUNT_W'(1));
                            r_stack <= r_stack >> DIGIT_W;
                            r_count <= r_count - 1'b1;
                            if (r_count == COUNT_W'(1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_osym;
    assign o_m_axis_tlast  = r_olast;

    // Stack never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DIGIT_DEPTH))
        else $error("digit stack count out of range");

    // Divider results only arrive while the sequencer is dividing
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider done outside division");

    // A value taken under a good config blocks further input on the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && cfg_ok) |=> !o_s_axis_tready)
        else $error("input ready right after taking a value");

    // A freshly loaded last symbol leaves no digits or sign behind
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && !r_neg && r_count == COUNT_W'(1))
        |=> (r_olast && r_count == '0 && !r_neg))
        else $error("last symbol issued with digits pending");

endmodule
